### rtl/tnrop_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Telnet receive option parser package
// Byte codes, parser phases, register indexes and the result group type.
// ----------------------------------------------------------------------------
package tnrop_pkg;

	localparam logic [7:0] B_IAC  = 8'd255;
	localparam logic [7:0] B_DONT = 8'd254;
	localparam logic [7:0] B_DO   = 8'd253;
	localparam logic [7:0] B_WONT = 8'd252;
	localparam logic [7:0] B_WILL = 8'd251;
	localparam logic [7:0] B_SB   = 8'd250;
	localparam logic [7:0] B_SE   = 8'd240;

	localparam logic [7:0] OPT_A_RESET = 8'd1;
	localparam logic [7:0] OPT_B_RESET = 8'd3;

	localparam logic REG_OPT_A = 1'b0;
	localparam logic REG_OPT_B = 1'b1;

	localparam logic [1:0] CMD_WILL = 2'd0;
	localparam logic [1:0] CMD_WONT = 2'd1;
	localparam logic [1:0] CMD_DO   = 2'd2;
	localparam logic [1:0] CMD_DONT = 2'd3;

	localparam logic [1:0] POS_FIRST  = 2'd0;
	localparam logic [1:0] POS_SECOND = 2'd1;
	localparam logic [1:0] POS_THIRD  = 2'd2;

	typedef enum logic [2:0] {
		PH_DATA   = 3'd0,
		PH_IAC    = 3'd1,
		PH_OPT    = 3'd2,
		PH_SUB    = 3'd3,
		PH_SUBIAC = 3'd4
	} phase_t;

	typedef struct packed {
		logic       reply;
		logic [7:0] data_byte;
		logic [7:0] cmd;
		logic       eoc;
		logic [1:0] last_pos;
	} grp_t;

endpackage
`default_nettype wire

### rtl/tnrop_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Telnet receive option parser: byte parser
// Holds the parse phase and the option registers, and turns each byte into
// a group of zero, one or three results.
// ----------------------------------------------------------------------------
module tnrop_parser (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cfg_we,
	input  wire              cfg_idx,
	input  wire  [7:0]       cfg_data,
	input  wire              take,
	input  wire  [7:0]       rx_byte,
	input  wire              eoc,
	output logic             grp_valid,
	output tnrop_pkg::grp_t  grp
);
	import tnrop_pkg::*;

	phase_t     phase_q;
	phase_t     phase_d;
	logic [1:0] held_q;
	logic [1:0] held_d;
	logic [7:0] opt_a_q;
	logic [7:0] opt_b_q;
	logic [7:0] cmd_diff;

	assign cmd_diff = rx_byte - B_WILL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opt_a_q <= OPT_A_RESET;
			opt_b_q <= OPT_B_RESET;
		end else if (cfg_we) begin
			if (cfg_idx == REG_OPT_A) begin
				opt_a_q <= cfg_data;
			end else begin
				opt_b_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DATA;
			held_q  <= CMD_WILL;
		end else if (take) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

	always_comb begin
		phase_d           = PH_DATA;
		held_d            = held_q;
		grp_valid         = 1'b0;
		grp.reply         = 1'b0;
		grp.data_byte     = rx_byte;
		grp.cmd           = B_WONT;
		grp.eoc           = eoc;
		grp.last_pos      = POS_FIRST;
		case (phase_q)
			PH_IAC: begin
				if (rx_byte == B_IAC) begin
					grp_valid = 1'b1;
				end else if (rx_byte >= B_WILL && rx_byte <= B_DONT) begin
					held_d  = cmd_diff[1:0];
					phase_d = PH_OPT;
				end else if (rx_byte == B_SB) begin
					phase_d = PH_SUB;
				end
			end
			PH_OPT: begin
				grp.reply    = 1'b1;
				grp.last_pos = POS_THIRD;
				if (held_q == CMD_DO) begin
					grp_valid = 1'b1;
					grp.cmd   = B_WONT;
				end else if (held_q == CMD_WILL) begin
					grp_valid = 1'b1;
					grp.cmd   = (rx_byte == opt_a_q || rx_byte == opt_b_q) ? B_DO : B_DONT;
				end
			end
			PH_SUB: begin
				phase_d = (rx_byte == B_IAC) ? PH_SUBIAC : PH_SUB;
			end
			PH_SUBIAC: begin
				phase_d = (rx_byte == B_SE) ? PH_DATA : PH_SUB;
			end
			default: begin
				if (rx_byte == B_IAC) begin
					phase_d = PH_IAC;
				end else begin
					grp_valid = 1'b1;
				end
			end
		endcase
	end

endmodule
`default_nettype wire

### rtl/tnrop_emitter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Telnet receive option parser: result emitter
// Holds one result group and sends its items one at a time through the
// output register.
// ----------------------------------------------------------------------------
module tnrop_emitter (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              new_take,
	input  wire              new_valid,
	input  tnrop_pkg::grp_t  new_grp,
	output logic             in_ready,
	output logic             out_valid,
	input  wire              out_ready,
	output logic             out_kind,
	output logic [7:0]       out_byte,
	output logic             out_last,
	output logic             out_cend
);
	import tnrop_pkg::*;

	grp_t       grp_q;
	logic       grp_valid_q;
	logic [1:0] pos_q;
	logic       out_valid_q;
	logic       kind_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       cend_q;
	logic       out_load;
	logic       move;
	logic       grp_done;
	logic [7:0] el_byte;
	logic       el_last;

	assign out_load = !out_valid_q || out_ready;
	assign move     = grp_valid_q && out_load;
	assign el_last  = (pos_q == grp_q.last_pos);
	assign grp_done = move && el_last;
	assign in_ready = !grp_valid_q || grp_done;

	always_comb begin
		el_byte = grp_q.data_byte;
		if (grp_q.reply) begin
			if (pos_q == POS_FIRST) begin
				el_byte = B_IAC;
			end else if (pos_q == POS_SECOND) begin
				el_byte = grp_q.cmd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_valid_q <= 1'b0;
			pos_q       <= POS_FIRST;
		end else begin
			if (grp_done) begin
				grp_valid_q <= 1'b0;
			end else if (move) begin
				pos_q <= pos_q + 2'd1;
			end
			if (new_take && new_valid) begin
				grp_valid_q <= 1'b1;
				pos_q       <= POS_FIRST;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (new_take && new_valid) begin
			grp_q <= new_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= grp_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			kind_q <= grp_q.reply;
			byte_q <= el_byte;
			last_q <= el_last;
			cend_q <= el_last & grp_q.eoc;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = kind_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;
	assign out_cend  = cend_q;

endmodule
`default_nettype wire

### rtl/telnet_receive_option_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Telnet receive option parser
// Strips IAC command sequences from a received telnet stream, passes data
// bytes on and answers DO and WILL negotiation with three-byte replies.
// ----------------------------------------------------------------------------
// An accepted item is stored in the result group register; its results then
// go one at a time through the output register. Throughput: one item per cycle
// while m_tready is high; an item with a three-byte reply holds the result
// group register until its third byte is sent; no-result items leave nothing.
// Reset (arst_n low) returns to the data phase and reloads the option defaults.
// ----------------------------------------------------------------------------
module telnet_receive_option_parser (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire        cfg_idx,
	input  wire  [7:0] cfg_data,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire  [7:0] s_tdata,  // [7:0] rx_byte
	input  wire        s_tlast,  // end_of_chunk
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [15:0] m_tdata, // [7:0] result_byte, [8] chunk_end, rest zero
	output logic       m_tuser,  // result_kind
	output logic       m_tlast   // last_of_run
);
	import tnrop_pkg::*;

	logic       take;
	logic       grp_valid;
	grp_t       grp;
	logic       in_ready;
	logic [7:0] out_byte;
	logic       out_cend;

	assign take     = s_tvalid && in_ready;
	assign s_tready = in_ready;

	tnrop_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.take      (take),
		.rx_byte   (s_tdata),
		.eoc       (s_tlast),
		.grp_valid (grp_valid),
		.grp       (grp)
	);

	tnrop_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.new_take  (take),
		.new_valid (grp_valid),
		.new_grp   (grp),
		.in_ready  (in_ready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (m_tuser),
		.out_byte  (out_byte),
		.out_last  (m_tlast),
		.out_cend  (out_cend)
	);

	assign m_tdata = {7'd0, out_cend, out_byte};

endmodule
`default_nettype wire
